>>> design/urr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range reporter package
// Shared widths, register indexes, reset values, job and state types, and
// the ASCII text of the messages.
// ----------------------------------------------------------------------------
package urr_pkg;

  localparam int COUNT_WIDTH_DEF = 8;
  localparam int DIST_W          = 16;   // widest echo count the divider handles
  localparam int WAIT_W          = 20;
  localparam int TRIG_W          = 8;
  localparam int LIMIT_W         = 8;
  localparam int SHIFT_W         = 3;
  localparam int CFG_DATA_W      = 20;
  localparam int CFG_IDX_W       = 2;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [WAIT_W-1:0]  HOLDOFF_RST = 20'd125000;
  localparam logic [TRIG_W-1:0]  TRIGGER_RST = 8'd2;
  localparam logic [LIMIT_W-1:0] TIMEOUT_RST = 8'd250;
  localparam logic [SHIFT_W-1:0] SHIFT_RST   = 3'd2;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x.
  localparam int               RECIP_W     = 17;
  localparam int               RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 17'd52429;

  localparam int NUM_DIGITS   = 3;
  localparam int RANGE_LEN    = 7;
  localparam int OUTRANGE_LEN = 10;
  localparam int BYTE_IDX_W   = 4;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_STAR = 8'h2A;
  localparam logic [7:0] ASCII_C    = 8'h63;
  localparam logic [7:0] ASCII_M    = 8'h6D;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLDOFF = 2'd0,
    CFG_TRIGGER = 2'd1,
    CFG_TIMEOUT = 2'd2,
    CFG_SHIFT   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [WAIT_W-1:0]  holdoff;
    logic [TRIG_W-1:0]  trigger;
    logic [LIMIT_W-1:0] timeout;
    logic [SHIFT_W-1:0] shift;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_HOLDOFF = 2'd0,
    PH_TRIGGER = 2'd1,
    PH_RISE    = 2'd2,
    PH_MEASURE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    JK_TICK     = 2'd0,
    JK_RANGE    = 2'd1,
    JK_OUTRANGE = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic              trig;
    logic [DIST_W-1:0] distance;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_DIGIT = 2'd1,
    BK_SEND  = 2'd2
  } back_state_t;

  function automatic logic [7:0] outrange_char(input logic [BYTE_IDX_W-1:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd1:    ch = 8'h4F;  // O
      4'd2:    ch = 8'h75;  // u
      4'd3:    ch = 8'h74;  // t
      4'd4:    ch = 8'h52;  // R
      4'd5:    ch = 8'h61;  // a
      4'd6:    ch = 8'h6E;  // n
      4'd7:    ch = 8'h67;  // g
      4'd8:    ch = 8'h65;  // e
      default: ch = ASCII_STAR;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

>>> design/urr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range reporter channels
// Valid/ready channels for timer ticks in and message results out.
// ----------------------------------------------------------------------------
interface urr_in_if;
  logic valid;
  logic ready;
  logic echo;
  modport source (output valid, output echo, input ready);
  modport sink (input valid, input echo, output ready);
endinterface

interface urr_out_if;
  logic       valid;
  logic       ready;
  logic       trig;
  logic       byte_valid;
  logic [7:0] tx_byte;
  logic       last;
  modport source (output valid, output trig, output byte_valid, output tx_byte,
                  output last, input ready);
  modport sink (input valid, input trig, input byte_valid, input tx_byte,
                input last, output ready);
endinterface
`default_nettype wire

>>> design/ultrasonic_range_reporter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic range reporter
// Echo-pulse rangefinder sequencer that reports each measurement as ASCII.
// ----------------------------------------------------------------------------
// Each input transaction is one timer tick with the sampled echo level. A tick
// that does not finish a measurement yields one result carrying the trigger
// level, and such ticks are accepted and answered one per cycle when the
// output is not stalled. A tick that finishes a measurement yields the bytes
// "*OutRange*" or "*DDDcm*"; the back end takes the job, runs the
// divide-by-ten unit once for each of the three digits of a distance, then
// sends the bytes in order. A four-entry job queue lets the front end keep
// accepting ticks while a message is being sent.
module ultrasonic_range_reporter import urr_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata,
  urr_in_if.sink                in_ch,
  urr_out_if.source             out_ch
);

  cfg_t cfg;
  logic push, push_ready, pop, pop_valid;
  job_t push_job, pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.holdoff <= HOLDOFF_RST;
      cfg.trigger <= TRIGGER_RST;
      cfg.timeout <= TIMEOUT_RST;
      cfg.shift   <= SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HOLDOFF: cfg.holdoff <= cfg_wdata[WAIT_W-1:0];
        CFG_TRIGGER: cfg.trigger <= cfg_wdata[TRIG_W-1:0];
        CFG_TIMEOUT: cfg.timeout <= cfg_wdata[LIMIT_W-1:0];
        CFG_SHIFT:   cfg.shift   <= cfg_wdata[SHIFT_W-1:0];
        default:     cfg.shift   <= cfg.shift;
      endcase
    end
  end

  urr_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .q_ready  (push_ready),
    .push     (push),
    .push_job (push_job)
  );

  urr_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job)
  );

  urr_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (pop_valid),
    .job       (pop_job),
    .job_pop   (pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

>>> design/urr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range reporter front end
// Runs the measurement sequence one tick per transaction and turns each tick
// into a job for the back end: a plain tick, a distance or an out-of-range.
// ----------------------------------------------------------------------------
module urr_front import urr_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  cfg_t        cfg,
  urr_in_if.sink      in_ch,
  input  wire         q_ready,
  output logic        push,
  output job_t        push_job
);

  phase_t                 phase, phase_next;
  logic [WAIT_W-1:0]      wait_count, wait_next, wait_inc;
  logic [COUNT_WIDTH-1:0] echo_count, count_next, count_inc;

  assign in_ch.ready = q_ready;
  assign push        = in_ch.valid && q_ready;

  assign wait_inc  = (wait_count == {WAIT_W{1'b1}}) ? wait_count : wait_count + 1'b1;
  assign count_inc = (echo_count == {COUNT_WIDTH{1'b1}}) ? echo_count
                                                         : echo_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HOLDOFF;
      wait_count <= '0;
      echo_count <= '0;
    end else if (push) begin
      phase      <= phase_next;
      wait_count <= wait_next;
      echo_count <= count_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    wait_next         = wait_count;
    count_next        = echo_count;
    push_job.kind     = JK_TICK;
    push_job.trig     = 1'b0;
    push_job.distance = '0;
    unique case (phase)
      PH_HOLDOFF: begin
        wait_next = wait_inc;
        if (wait_inc >= cfg.holdoff) begin
          phase_next = PH_TRIGGER;
          wait_next  = '0;
        end
      end
      PH_TRIGGER: begin
        push_job.trig = 1'b1;
        wait_next     = wait_inc;
        if (wait_inc >= WAIT_W'(cfg.trigger)) begin
          phase_next = PH_RISE;
          wait_next  = '0;
        end
      end
      PH_RISE: begin
        if (in_ch.echo) begin
          phase_next = PH_MEASURE;
          count_next = '0;
        end
      end
      PH_MEASURE: begin
        if (in_ch.echo) begin
          count_next = count_inc;
          if (count_inc > COUNT_WIDTH'(cfg.timeout)) begin
            push_job.kind = JK_OUTRANGE;
            phase_next    = PH_HOLDOFF;
            wait_next     = '0;
          end
        end else begin
          push_job.kind     = JK_RANGE;
          push_job.distance = DIST_W'(echo_count >> cfg.shift);
          phase_next        = PH_HOLDOFF;
          wait_next         = '0;
        end
      end
      default: phase_next = PH_HOLDOFF;
    endcase
  end

endmodule
`default_nettype wire

>>> design/urr_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range reporter job queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module urr_fifo import urr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire   clk,
  input  wire   rst,
  input  wire   push,
  input  job_t  push_job,
  output logic  push_ready,
  input  wire   pop,
  output logic  pop_valid,
  output job_t  pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

>>> design/urr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range reporter back end
// Takes jobs from the queue, converts distances to three decimal digits with
// one divide-by-ten step per cycle, and sends results through an output
// register, one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module urr_back import urr_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         job_valid,
  input  job_t        job,
  output logic        job_pop,
  urr_out_if.source   out_ch
);

  localparam int PROD_W = DIST_W + RECIP_W;

  back_state_t            state, state_next;
  logic                   is_out;
  logic [COUNT_WIDTH-1:0] value;
  logic [3:0]             digit [NUM_DIGITS];
  logic [1:0]             dstep;
  logic [BYTE_IDX_W-1:0]  idx, idx_last;

  logic                   out_valid, out_trig, out_bv, out_last;
  logic [7:0]             out_byte;
  logic                   load_ok, ld, ld_trig, ld_bv, ld_last;
  logic [7:0]             ld_byte, send_char;

  logic [DIST_W-1:0]      div_in, rem_full;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-RECIP_SHIFT-1:0] quot;

  assign out_ch.valid      = out_valid;
  assign out_ch.trig       = out_trig;
  assign out_ch.byte_valid = out_bv;
  assign out_ch.tx_byte    = out_byte;
  assign out_ch.last       = out_last;

  assign load_ok = !out_valid || out_ch.ready;

  // One divide-by-ten step: quotient by reciprocal multiply, then remainder.
  assign div_in   = DIST_W'(value);
  assign prod     = PROD_W'(div_in) * PROD_W'(RECIP_TEN);
  assign quot     = prod[PROD_W-1:RECIP_SHIFT];
  assign rem_full = div_in - DIST_W'({quot, 3'b000}) - DIST_W'({quot, 1'b0});

  assign idx_last = is_out ? BYTE_IDX_W'(OUTRANGE_LEN - 1) : BYTE_IDX_W'(RANGE_LEN - 1);

  always_comb begin
    if (is_out) begin
      send_char = outrange_char(idx);
    end else begin
      case (idx)
        4'd0:    send_char = ASCII_STAR;
        4'd1:    send_char = ASCII_ZERO + {4'b0000, digit[2]};
        4'd2:    send_char = ASCII_ZERO + {4'b0000, digit[1]};
        4'd3:    send_char = ASCII_ZERO + {4'b0000, digit[0]};
        4'd4:    send_char = ASCII_C;
        4'd5:    send_char = ASCII_M;
        default: send_char = ASCII_STAR;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    ld         = 1'b0;
    ld_trig    = 1'b0;
    ld_bv      = 1'b0;
    ld_byte    = '0;
    ld_last    = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (job_valid && load_ok) begin
          job_pop = 1'b1;
          unique case (job.kind)
            JK_TICK: begin
              ld      = 1'b1;
              ld_trig = job.trig;
              ld_last = 1'b1;
            end
            JK_OUTRANGE: state_next = BK_SEND;
            JK_RANGE:    state_next = BK_DIGIT;
            default:     state_next = BK_IDLE;
          endcase
        end
      end
      BK_DIGIT: begin
        if (dstep == 2'(NUM_DIGITS - 1)) begin
          state_next = BK_SEND;
        end
      end
      BK_SEND: begin
        if (load_ok) begin
          ld      = 1'b1;
          ld_bv   = 1'b1;
          ld_byte = send_char;
          ld_last = (idx == idx_last);
          if (idx == idx_last) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ld) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_trig <= ld_trig;
      out_bv   <= ld_bv;
      out_byte <= ld_byte;
      out_last <= ld_last;
    end
    if (state == BK_IDLE && job_pop) begin
      is_out <= (job.kind == JK_OUTRANGE);
      value  <= COUNT_WIDTH'(job.distance);
      dstep  <= '0;
      idx    <= '0;
    end
    if (state == BK_DIGIT) begin
      digit[dstep] <= rem_full[3:0];
      value        <= COUNT_WIDTH'(quot);
      dstep        <= dstep + 1'b1;
    end
    if (state == BK_SEND && load_ok) begin
      idx <= idx + 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> design/urr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range reporter checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module urr_checker import urr_pkg::*; (
  input wire       clk,
  input wire       rst,
  input wire       out_valid,
  input wire       out_ready,
  input wire       trig,
  input wire       byte_valid,
  input wire [7:0] tx_byte,
  input wire       last
);

  // A result without a message byte is always a whole tick on its own.
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> tx_byte == 8'h00 && last)
    else $error("tick result carries a byte or is not last");

  a_no_trig_in_msg: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> !trig)
    else $error("trigger driven during a message byte");

  // Both messages end with an asterisk.
  a_msg_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid && last |-> tx_byte == ASCII_STAR)
    else $error("message does not end with an asterisk");

  // Bytes of one message follow each other without a gap.
  a_msg_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && byte_valid && !last |=> out_valid && byte_valid)
    else $error("gap inside a message");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(last))
    else $error("stalled result changed");

endmodule

bind ultrasonic_range_reporter urr_checker u_urr_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .trig       (out_ch.trig),
  .byte_valid (out_ch.byte_valid),
  .tx_byte    (out_ch.tx_byte),
  .last       (out_ch.last)
);
`default_nettype wire
